// ===== design/literal_find_and_replace_top_macros.svh =====
// Assertion macros for the literal find-and-replace block.
// Included by the top level; needs clock and reset in scope where used.
`ifndef LITERAL_FIND_AND_REPLACE_TOP_MACROS_SVH
`define LITERAL_FIND_AND_REPLACE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge.
`define LFR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("lfr: assertion failed");
// Condition in one cycle implies a consequence in the next.
`define LFR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lfr: next-cycle assertion failed");
`else
`define LFR_ASSERT(lbl, prop)
`define LFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/lfr_pkg.sv =====
// Shared constants, register codes and job types for literal find-and-replace.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lfr_pkg;

   localparam int LFR_PATTERN_MAX_DEF = 8;
   localparam int LFR_REPLACE_MAX_DEF = 8;

   // Configuration port
   localparam int LFR_CSR_IDX_W  = 3;
   localparam int LFR_CSR_DATA_W = 64;
   localparam logic [LFR_CSR_IDX_W-1:0] LFR_REG_PATTERN_BYTES      = 3'd0;
   localparam logic [LFR_CSR_IDX_W-1:0] LFR_REG_PATTERN_LENGTH     = 3'd1;
   localparam logic [LFR_CSR_IDX_W-1:0] LFR_REG_REPLACEMENT_BYTES  = 3'd2;
   localparam logic [LFR_CSR_IDX_W-1:0] LFR_REG_REPLACEMENT_LENGTH = 3'd3;
   localparam logic [LFR_CSR_IDX_W-1:0] LFR_REG_MAX_REPLACEMENTS   = 3'd4;

   localparam logic [16:0] LFR_MAX_REP_UNLIMITED = 17'h1FFFF;
   localparam logic [15:0] LFR_COUNT_SAT         = 16'hFFFF;

   // Job queue between front and back (depth is a power of two)
   localparam int LFR_QUEUE_DEPTH = 2;
   localparam int LFR_QPTR_W      = 1;
   localparam int LFR_QLVL_W      = 2;

   typedef struct packed {
      logic        last;
      logic [15:0] count;
   } lfr_job_ctl_type;

   localparam int LFR_JOB_CTL_W = $bits(lfr_job_ctl_type);

   function automatic int lfr_max(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

// ===== design/lfr_front.sv =====
// Front end: config registers, match window and compare; builds at most one job per byte.
// Depends on lfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfr_front import lfr_pkg::*; #(
   parameter int PATTERN_MAX = LFR_PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = LFR_REPLACE_MAX_DEF,
   parameter int LANES       = lfr_max(PATTERN_MAX, REPLACE_MAX),
   parameter int NW          = $clog2(LANES + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [LFR_CSR_IDX_W-1:0]  csr_index,
   input  wire logic [LFR_CSR_DATA_W-1:0] csr_wr_data,
   input  wire logic                      in_fire,
   input  wire logic [7:0]                in_data_byte,
   input  wire logic                      in_last,
   output logic                           job_push,
   output logic [NW-1:0]                  job_n,
   output logic [LANES*8-1:0]             job_bytes,
   output lfr_job_ctl_type                job_ctl
);

   localparam int PLW = $clog2(PATTERN_MAX + 1);

   logic [63:0]            pat_bytes_ff;
   logic [3:0]             pat_len_ff;
   logic [63:0]            rep_bytes_ff;
   logic [3:0]             rep_len_ff;
   logic [16:0]            max_rep_ff;

   logic [PATTERN_MAX*8-1:0] win_ff, win_in;
   logic [PLW-1:0]           fill_ff, fill_in;
   logic [15:0]              count_ff, count_in;
   logic                     in_string_ff, in_string_in;
   logic [PLW-1:0]           act_len_ff, act_len_in;

   logic [PLW-1:0]           p, p_cfg, fill, fill_inc;
   logic [NW-1:0]            rl;
   logic [15:0]              cnt, cnt_next;
   logic [PATTERN_MAX*8-1:0] wnew;
   logic                     full, hit, allowed, replace;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bytes_ff <= '0;
         pat_len_ff   <= '0;
         rep_bytes_ff <= '0;
         rep_len_ff   <= '0;
         max_rep_ff   <= LFR_MAX_REP_UNLIMITED;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            LFR_REG_PATTERN_BYTES:      pat_bytes_ff <= csr_wr_data;
            LFR_REG_PATTERN_LENGTH:     pat_len_ff   <= csr_wr_data[3:0];
            LFR_REG_REPLACEMENT_BYTES:  rep_bytes_ff <= csr_wr_data;
            LFR_REG_REPLACEMENT_LENGTH: rep_len_ff   <= csr_wr_data[3:0];
            LFR_REG_MAX_REPLACEMENTS:   max_rep_ff   <= csr_wr_data[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // clamp lengths to what the hardware holds
      if (int'(pat_len_ff) > PATTERN_MAX) p_cfg = PLW'(PATTERN_MAX);
      else                                p_cfg = PLW'(pat_len_ff);
      if (int'(rep_len_ff) > REPLACE_MAX) rl = NW'(REPLACE_MAX);
      else                                rl = NW'(rep_len_ff);

      p    = in_string_ff ? act_len_ff : p_cfg;
      cnt  = in_string_ff ? count_ff : '0;
      fill = in_string_ff ? fill_ff : '0;
      fill_inc = fill + PLW'(1);

      // window with the new byte appended
      for (int i = 0; i < PATTERN_MAX; i++) begin
         wnew[8*i +: 8] = (PLW'(i) == fill) ? in_data_byte : win_ff[8*i +: 8];
      end

      hit = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if ((PLW'(i) < p) && (wnew[8*i +: 8] != 8'(pat_bytes_ff >> (8*i)))) hit = 1'b0;
      end

      full    = (p != '0) && (fill_inc == p);
      allowed = max_rep_ff[16] || (cnt < max_rep_ff[15:0]);
      replace = full && hit && allowed;
      cnt_next = (replace && (cnt != LFR_COUNT_SAT)) ? cnt + 16'd1 : cnt;

      // job content
      for (int i = 0; i < LANES; i++) begin
         job_bytes[8*i +: 8] = replace ? 8'(rep_bytes_ff >> (8*i)) : 8'(wnew >> (8*i));
      end
      if (p == '0)      job_n = NW'(1);
      else if (replace) job_n = rl;
      else if (full)    job_n = in_last ? NW'(p) : NW'(1);
      else              job_n = in_last ? NW'(fill_inc) : '0;

      job_ctl.last  = in_last;
      job_ctl.count = cnt_next;
      job_push      = in_fire && ((job_n != '0) || in_last);

      // next window state
      in_string_in = in_string_ff;
      act_len_in   = act_len_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      win_in       = win_ff;
      if (in_fire) begin
         in_string_in = !in_last;
         act_len_in   = p;
         count_in     = cnt_next;
         if ((p == '0) || replace || in_last) begin
            fill_in = '0;
         end else if (full) begin
            fill_in = fill;           // oldest byte leaves, fill stays p-1
            win_in  = wnew >> 8;
         end else begin
            fill_in = fill_inc;
            win_in  = wnew;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
         fill_ff      <= '0;
         count_ff     <= '0;
         act_len_ff   <= '0;
      end else begin
         in_string_ff <= in_string_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         act_len_ff   <= act_len_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

// ===== design/lfr_queue.sv =====
// Two-entry job queue between front and back.
// Depends on lfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfr_queue import lfr_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data,
   output logic                  full,
   output logic [LFR_QLVL_W-1:0] level
);

   logic [WIDTH-1:0]      mem_ff [LFR_QUEUE_DEPTH];
   logic [LFR_QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [LFR_QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LFR_QLVL_W-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + LFR_QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + LFR_QPTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + LFR_QLVL_W'(push) - LFR_QLVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign head_valid = (level_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign full       = (level_ff == LFR_QLVL_W'(LFR_QUEUE_DEPTH));
   assign level      = level_ff;

endmodule

`default_nettype wire

// ===== design/lfr_back.sv =====
// Back end: holds one job and plays its bytes out one beat per cycle while rsp_stall is low.
// Depends on lfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfr_back import lfr_pkg::*; #(
   parameter int LANES = LFR_PATTERN_MAX_DEF,
   parameter int NW    = $clog2(LANES + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire logic [NW-1:0]        head_n,
   input  wire logic [LANES*8-1:0]   head_bytes,
   input  wire lfr_job_ctl_type      head_ctl,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_out_valid,
   output logic                      rsp_end_of_string,
   output logic [15:0]               rsp_replace_count
);

   logic                 busy_ff, busy_in;
   logic [NW-1:0]        idx_ff, idx_in;
   logic [NW-1:0]        n_ff;
   logic [LANES*8-1:0]   bytes_ff;
   lfr_job_ctl_type      ctl_ff;
   logic                 final_beat, beat_done;

   always_comb begin
      final_beat = (n_ff == '0) || ((idx_ff + NW'(1)) == n_ff);
      beat_done  = busy_ff && !rsp_stall;
      pop        = head_valid && (!busy_ff || (beat_done && final_beat));
      busy_in    = pop || (busy_ff && !(beat_done && final_beat));
      if (pop)            idx_in = '0;
      else if (beat_done) idx_in = idx_ff + NW'(1);
      else                idx_in = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         n_ff     <= head_n;
         bytes_ff <= head_bytes;
         ctl_ff   <= head_ctl;
      end
   end

   assign rsp_valid         = busy_ff;
   assign rsp_out_valid     = (n_ff != '0);
   assign rsp_out_byte      = rsp_out_valid ? 8'(bytes_ff >> {idx_ff, 3'b000}) : 8'h00;
   assign rsp_end_of_string = ctl_ff.last && final_beat;
   assign rsp_replace_count = ctl_ff.count;

endmodule

`default_nettype wire

// ===== design/literal_find_and_replace_top.sv =====
// Top level of the literal find-and-replace block: front, job queue, back.
// Depends on lfr_pkg, lfr_front, lfr_queue, lfr_back and the macro header.
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_stall  | data_byte, last
//   rsp     | out       | rsp_valid/rsp_stall  | out_byte, out_valid, end_of_string,
//           |           |                      |   replace_count
//   csr     | in        | csr_wr_en            | csr_index, csr_wr_data
//
// The front takes one req beat per cycle whenever the job queue is not full.
// Each req beat yields zero to max(PATTERN_MAX, REPLACE_MAX) rsp beats, which the
// back plays out at one beat per cycle while rsp_stall is low; the back's single output
// port sets the sustained rate, so a long replacement burst can hold req off.
// Between a req beat and its first rsp beat the job is registered in the queue, then in the back.
// Reset is synchronous; it clears the window fill state, counters, queue and config registers.
// req_stall is the queue-full flag and does not depend on req_valid.
`timescale 1ns / 1ps
`default_nettype none
`include "literal_find_and_replace_top_macros.svh"

module literal_find_and_replace_top import lfr_pkg::*; #(
   parameter int PATTERN_MAX = LFR_PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = LFR_REPLACE_MAX_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // configuration
   input  wire logic                      csr_wr_en,
   input  wire logic [LFR_CSR_IDX_W-1:0]  csr_index,
   input  wire logic [LFR_CSR_DATA_W-1:0] csr_wr_data,
   // source bytes
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_data_byte,
   input  wire logic                      req_last,
   // result bytes
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_out_valid,
   output logic                           rsp_end_of_string,
   output logic [15:0]                    rsp_replace_count
);

   // Job lanes cover the longest burst one byte can cause: a full window
   // flush or a full replacement.
   localparam int LANES = lfr_max(PATTERN_MAX, REPLACE_MAX);
   localparam int NW    = $clog2(LANES + 1);
   localparam int JOB_W = LFR_JOB_CTL_W + NW + LANES*8;

   logic                   in_fire;
   logic                   job_push;
   logic [NW-1:0]          job_n;
   logic [LANES*8-1:0]     job_bytes;
   lfr_job_ctl_type        job_ctl;

   logic                   q_full;
   logic                   q_pop;
   logic                   q_head_valid;
   logic [JOB_W-1:0]       q_head_data;
   logic [LFR_QLVL_W-1:0]  q_level;

   lfr_job_ctl_type        head_ctl;
   logic [NW-1:0]          head_n;
   logic [LANES*8-1:0]     head_bytes;

   // A source beat is taken whenever the queue has room, even if it makes no job.
   assign req_stall = q_full;
   assign in_fire   = req_valid && !req_stall;

   // Front: window, compare, replacement count, job assembly.
   lfr_front #(
      .PATTERN_MAX (PATTERN_MAX),
      .REPLACE_MAX (REPLACE_MAX),
      .LANES       (LANES),
      .NW          (NW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .in_fire      (in_fire),
      .in_data_byte (req_data_byte),
      .in_last      (req_last),
      .job_push     (job_push),
      .job_n        (job_n),
      .job_bytes    (job_bytes),
      .job_ctl      (job_ctl)
   );

   // Queue decouples the two halves so a long burst on rsp does not block
   // the next source beat right away.
   lfr_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  ({job_ctl, job_n, job_bytes}),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .full       (q_full),
      .level      (q_level)
   );

   assign {head_ctl, head_n, head_bytes} = q_head_data;

   // Back: serializes a job; a job with no bytes is the empty end marker.
   lfr_back #(
      .LANES (LANES),
      .NW    (NW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (q_head_valid),
      .head_n            (head_n),
      .head_bytes        (head_bytes),
      .head_ctl          (head_ctl),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_replace_count (rsp_replace_count)
   );

   // An empty beat only ever closes a string.
   `LFR_ASSERT(a_empty_ends_string, (rsp_valid && !rsp_out_valid) |-> rsp_end_of_string)
   // An idle back picks up a waiting job on the next edge.
   `LFR_ASSERT_NEXT(a_back_picks_up, (q_level != '0) && !rsp_valid, rsp_valid)
   // The queue never holds more jobs than it has entries.
   `LFR_ASSERT(a_queue_bound, q_level <= LFR_QLVL_W'(LFR_QUEUE_DEPTH))

endmodule

`default_nettype wire
